// ===== rtl/lenticular_subpixel_view_router_defines.svh =====
// Assertion macros shared by the lenticular subpixel view router RTL.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef LENTICULAR_SUBPIXEL_VIEW_ROUTER_DEFINES_SVH
`define LENTICULAR_SUBPIXEL_VIEW_ROUTER_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define LSVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition in one cycle implies an outcome in the next.
`define LSVR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`else

`define LSVR_ASSERT(label, prop, msg)
`define LSVR_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== rtl/lsvr_pkg.sv =====
// Package of the lenticular subpixel view router: widths, constants and
// the item types that travel between the pipeline modules. No dependencies.
`timescale 1ns / 1ps

package lsvr_pkg;

  // Fixed point and field widths.
  localparam int FRAC_BITS = 16;
  localparam int MAX_VIEWS = 64;
  localparam int COORD_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int VIEW_W    = 6;
  localparam int NLANE     = 3;

  // Configuration register widths.
  localparam int OFFS_W = 21;
  localparam int SLOPE_W = 18;
  localparam int PER_W  = 23;
  localparam int VCNT_W = 7;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_LENS_OFFSET = 2'd0,
    REG_LENS_SLOPE  = 2'd1,
    REG_LENS_PERIOD = 2'd2,
    REG_VIEW_COUNT  = 2'd3
  } lens_reg_e;

  // Three times a coordinate plus two fits in this many bits.
  localparam int SUB_W = COORD_W + 2;
  // Signed phase: the shifted position stays below 2^30 and the slant term
  // below 2^31 in magnitude, so 33 bits hold it and 32 bits its magnitude.
  localparam int PH_W  = 33;
  localparam int MAG_W = PH_W - 1;

  // Remainder unit: restoring steps spread over pipeline stages.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = MAG_W / DIV_STEPS;

  // View quotient: remainder times view count, divided by the period.
  localparam int PROD_W = PER_W + VCNT_W;
  localparam int QUO_W  = $clog2(MAX_VIEWS);
  localparam int QREM_W = PROD_W - QUO_W;

  typedef struct packed {
    logic signed [OFFS_W-1:0]  offset;
    logic signed [SLOPE_W-1:0] slope;
    logic [PER_W-1:0]          period;
    logic [VCNT_W-1:0]         views;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  red;
    logic [BYTE_W-1:0]  green;
    logic [BYTE_W-1:0]  blue;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pix_t;

  // One subpixel lane inside the remainder unit.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [PER_W-1:0] rem;
  } mod_lane_t;

  typedef struct packed {
    pix_t                        pix;
    mod_lane_t [NLANE-1:0]       lane;
  } mod_item_t;

  typedef struct packed {
    pix_t                        pix;
    logic [NLANE-1:0][VIEW_W-1:0] view;
  } view_item_t;

endpackage

// ===== rtl/lsvr_phase.sv =====
// Phase front end: slant product, then the signed phase of each subpixel.
// Two register stages. Depends on lsvr_pkg.
`timescale 1ns / 1ps

module lsvr_phase (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  lsvr_pkg::cfg_t      cfg_i,
  input  lsvr_pkg::pix_t      pix_i,
  output lsvr_pkg::mod_item_t item_o
);
  import lsvr_pkg::*;

  logic [SUB_W-1:0]       row3;
  logic signed [PH_W-1:0] prod_d;
  logic signed [PH_W-1:0] prod_q;
  pix_t                   pix_q;
  mod_item_t              item_d;
  mod_item_t              item_q;

  // First stage: three times the row, times the slant.
  always_comb begin
    row3   = {2'b00, pix_i.y} + {1'b0, pix_i.y, 1'b0};
    prod_d = $signed({1'b0, row3}) * cfg_i.slope;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pix_q  <= pix_i;
      prod_q <= prod_d;
    end
  end

  // Second stage: phase of each subpixel, split into sign and magnitude.
  always_comb begin
    logic [SUB_W-1:0]       sp;
    logic signed [PH_W-1:0] ph;
    logic [PH_W-1:0]        mag_full;
    item_d.pix = pix_q;
    for (int k = 0; k < NLANE; k++) begin
      sp = {2'b00, pix_q.x} + {1'b0, pix_q.x, 1'b0} + SUB_W'(k);
      ph = $signed(PH_W'({sp, {FRAC_BITS{1'b0}}})) + PH_W'($signed(cfg_i.offset)) - prod_q;
      mag_full = ph[PH_W-1] ? PH_W'(-ph) : PH_W'(ph);
      item_d.lane[k].neg = ph[PH_W-1];
      item_d.lane[k].mag = mag_full[MAG_W-1:0];
      item_d.lane[k].rem = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== rtl/lsvr_mod_stage.sv =====
// One stage of the pipelined remainder unit: a few restoring steps on each
// of the three subpixel lanes, then a register. Depends on lsvr_pkg.
`timescale 1ns / 1ps

module lsvr_mod_stage (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [lsvr_pkg::PER_W-1:0] period_i,
  input  lsvr_pkg::mod_item_t     item_i,
  output lsvr_pkg::mod_item_t     item_o
);
  import lsvr_pkg::*;

  mod_item_t item_d;
  mod_item_t item_q;

  // Shift the next dividend bit into the remainder and subtract the period
  // when it fits; the quotient itself is not needed.
  always_comb begin
    logic [PER_W:0]   t;
    logic [PER_W:0]   diff;
    logic [PER_W-1:0] rem;
    logic [MAG_W-1:0] mag;
    item_d.pix = item_i.pix;
    for (int k = 0; k < NLANE; k++) begin
      rem = item_i.lane[k].rem;
      mag = item_i.lane[k].mag;
      for (int s = 0; s < DIV_STEPS; s++) begin
        t    = {rem, mag[MAG_W-1]};
        diff = t - {1'b0, period_i};
        if (t >= {1'b0, period_i}) begin
          rem = diff[PER_W-1:0];
        end else begin
          rem = t[PER_W-1:0];
        end
        mag = {mag[MAG_W-2:0], 1'b0};
      end
      item_d.lane[k].neg = item_i.lane[k].neg;
      item_d.lane[k].mag = mag;
      item_d.lane[k].rem = rem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== rtl/lsvr_view.sv =====
// View back end: floored remainder, scale by the view count, short
// quotient and clamp. Three register stages. Depends on lsvr_pkg.
`timescale 1ns / 1ps

module lsvr_view (
  input  logic                 clk_i,
  input  logic [2:0]           en_i,
  input  lsvr_pkg::cfg_t       cfg_i,
  input  lsvr_pkg::mod_item_t  item_i,
  output lsvr_pkg::view_item_t item_o
);
  import lsvr_pkg::*;

  logic [VCNT_W-1:0]              views_c;
  logic [NLANE-1:0][PER_W-1:0]    r_d;
  logic [NLANE-1:0][PER_W-1:0]    r_q;
  logic [NLANE-1:0][PROD_W-1:0]   prod_d;
  logic [NLANE-1:0][PROD_W-1:0]   prod_q;
  pix_t                           pix_r_q;
  pix_t                           pix_p_q;
  view_item_t                     item_d;
  view_item_t                     item_q;

  // Counts above the supported number of views act as the maximum.
  assign views_c = (cfg_i.views > VCNT_W'(MAX_VIEWS)) ? VCNT_W'(MAX_VIEWS) : cfg_i.views;

  // A negative phase with a nonzero remainder folds up into the period.
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      if (item_i.lane[k].neg && (item_i.lane[k].rem != '0)) begin
        r_d[k] = cfg_i.period - item_i.lane[k].rem;
      end else begin
        r_d[k] = item_i.lane[k].rem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pix_r_q <= item_i.pix;
      r_q     <= r_d;
    end
  end

  // Remainder times the view count.
  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      prod_d[k] = PROD_W'(r_q[k]) * PROD_W'(views_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      pix_p_q <= pix_r_q;
      prod_q  <= prod_d;
    end
  end

  // The product is below the view count times the period, so the quotient
  // has only a few bits; the upper product bits start the remainder.
  always_comb begin
    logic [QREM_W-1:0] rem;
    logic [QREM_W:0]   t;
    logic [QREM_W:0]   diff;
    logic [QUO_W-1:0]  q;
    logic [VIEW_W-1:0] v;
    item_d.pix = pix_p_q;
    for (int k = 0; k < NLANE; k++) begin
      rem = prod_q[k][PROD_W-1:QUO_W];
      q   = '0;
      for (int j = QUO_W - 1; j >= 0; j--) begin
        t    = {rem, prod_q[k][j]};
        diff = t - (QREM_W + 1)'(cfg_i.period);
        if (t >= (QREM_W + 1)'(cfg_i.period)) begin
          q[j] = 1'b1;
          rem  = diff[QREM_W-1:0];
        end else begin
          rem  = t[QREM_W-1:0];
        end
      end
      v = VIEW_W'(q);
      if ({1'b0, v} >= views_c) begin
        v = VIEW_W'(views_c - VCNT_W'(1));
      end
      if ((cfg_i.period == '0) || (views_c == '0)) begin
        v = '0;
      end
      item_d.view[k] = v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== rtl/lenticular_subpixel_view_router.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   48     pixel position and blue, green, red bytes
// m_axis    out  72     position, view of each subpixel, bytes
// cfg       in   23     lens offset, slope, period, view count
//
// One item per clock sustained while m_axis_tready stays high. The path
// holds the 32-step remainder by the lens period, four steps in each of
// eight stages, plus two phase and three view stages.
// Reset clears the stage valid bits and loads the register reset values.
// Each stage holds its item while the next is full and cannot move on, so a
// stalled output backs up stage by stage and empty stages still fill behind it.
// Top level of the lenticular subpixel view router; uses lsvr_pkg,
// lsvr_phase, lsvr_mod_stage, lsvr_view and the assertion macro header.
`timescale 1ns / 1ps
`include "lenticular_subpixel_view_router_defines.svh"

module lenticular_subpixel_view_router (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [22:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], in_blue[31:24], in_green[39:32], in_red[47:40]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_x[11:0], out_y[23:12], view_blue[29:24], view_green[35:30],
  // view_red[41:36], out_blue[49:42], out_green[57:50], out_red[65:58], zeros
  output logic [71:0] m_axis_tdata
);
  import lsvr_pkg::*;

  localparam logic [PER_W-1:0]  PERIOD_RESET = PER_W'(327680);
  localparam logic [VCNT_W-1:0] VIEWS_RESET  = VCNT_W'(8);

  localparam int ST_A    = 0;
  localparam int ST_B    = 1;
  localparam int ST_DIV0 = 2;
  localparam int ST_D    = ST_DIV0 + DIV_STAGES;
  localparam int ST_F    = ST_D + 2;
  localparam int NSTAGE  = ST_F + 1;

  cfg_t                  cfg_q;
  logic [NSTAGE-1:0]     valid_q;
  logic [NSTAGE-1:0]     valid_d;
  logic [NSTAGE:0]       adv;
  logic [NSTAGE-1:0]     hold;
  pix_t                  pix_in;
  mod_item_t             div_item [DIV_STAGES+1];
  view_item_t            out_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.offset <= '0;
      cfg_q.slope  <= '0;
      cfg_q.period <= PERIOD_RESET;
      cfg_q.views  <= VIEWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_LENS_OFFSET: cfg_q.offset <= cfg_wdata_i[OFFS_W-1:0];
        REG_LENS_SLOPE:  cfg_q.slope  <= cfg_wdata_i[SLOPE_W-1:0];
        REG_LENS_PERIOD: cfg_q.period <= cfg_wdata_i[PER_W-1:0];
        REG_VIEW_COUNT:  cfg_q.views  <= cfg_wdata_i[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: a stage loads when it is empty or its item moves on.
  assign adv[NSTAGE] = m_axis_tready;
  for (genvar i = 0; i < NSTAGE; i++) begin : g_adv
    assign adv[i] = !valid_q[i] || adv[i+1];
  end

  assign valid_d[0] = adv[0] ? s_axis_tvalid : valid_q[0];
  for (genvar i = 1; i < NSTAGE; i++) begin : g_valid
    assign valid_d[i] = adv[i] ? valid_q[i-1] : valid_q[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign hold = valid_q & ~adv[NSTAGE:1];

  // Input item unpacking.
  assign pix_in.x     = s_axis_tdata[11:0];
  assign pix_in.y     = s_axis_tdata[23:12];
  assign pix_in.blue  = s_axis_tdata[31:24];
  assign pix_in.green = s_axis_tdata[39:32];
  assign pix_in.red   = s_axis_tdata[47:40];

  // Phase front end.
  lsvr_phase u_phase (
    .clk_i  (clk_i),
    .en_i   (adv[ST_B:ST_A]),
    .cfg_i  (cfg_q),
    .pix_i  (pix_in),
    .item_o (div_item[0])
  );

  // Remainder by the lens period.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    lsvr_mod_stage u_mod (
      .clk_i    (clk_i),
      .en_i     (adv[ST_DIV0+g]),
      .period_i (cfg_q.period),
      .item_i   (div_item[g]),
      .item_o   (div_item[g+1])
    );
  end

  // View index and clamp; its last register drives the output.
  lsvr_view u_view (
    .clk_i  (clk_i),
    .en_i   (adv[ST_F:ST_D]),
    .cfg_i  (cfg_q),
    .item_i (div_item[DIV_STAGES]),
    .item_o (out_item)
  );

  // Ports.
  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid_q[NSTAGE-1];
  assign m_axis_tdata  = {6'b000000, out_item.pix.red, out_item.pix.green, out_item.pix.blue,
                          out_item.view[2], out_item.view[1], out_item.view[0],
                          out_item.pix.y, out_item.pix.x};

  // A stage that cannot pass its item on keeps it.
  `LSVR_ASSERT_NEXT(a_stage_hold, (hold != '0), (($past(hold) & ~valid_q) == '0), "stage dropped a held item")

  // A stage only becomes full from the stage before it.
  `LSVR_ASSERT(a_fill_order, ((valid_q[NSTAGE-1:1] & ~$past(valid_q[NSTAGE-1:1]) & ~$past(valid_q[NSTAGE-2:0])) == '0), "stage filled without a predecessor item")

  // An accepted item enters the first stage.
  `LSVR_ASSERT_NEXT(a_accept_enters, (s_axis_tvalid && s_axis_tready), valid_q[0], "accepted item missing from first stage")

endmodule
